// ----- src/ebr_pkg.sv -----
// ----------------------------------------------------------------------------
// ebr_pkg
// Shared types and constants for the Exp-Golomb bit reader.
// ----------------------------------------------------------------------------
package ebr_pkg;

  localparam int BUFFER_BYTES_DEF = 4096;
  localparam int VALUE_W          = 33;
  localparam int ACC_W            = 32;
  localparam int CNT_W            = 6;
  localparam int MAX_FIXED        = 32;
  localparam int MAX_ZEROS        = 32;
  localparam int S_TDATA_W        = 16;
  localparam int S_TUSER_W        = 3;
  localparam int M_TDATA_W        = 40;
  localparam int M_TUSER_W        = 2;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_FIXED = 2'd1,
    REQ_UE    = 2'd2,
    REQ_SE    = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_BITS  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               exhausted;
    logic               code_error;
  } res_t;

endpackage

// ----- src/ebr_store.sv -----
// ----------------------------------------------------------------------------
// ebr_store
// Byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ebr_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/ebr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ebr_ctrl
// Read position, fill count and the bit sequencer for fixed, ue and se reads.
// ----------------------------------------------------------------------------
module ebr_ctrl #(
  parameter int BUFFER_BYTES = 4096,
  parameter int AW           = 12,
  parameter int IDXW         = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [7:0]          byte_value,
  input  logic                new_buffer,
  input  logic [5:0]          bit_count,
  input  logic                out_free,
  output ebr_pkg::res_t       res,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [7:0]          wr_data,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data
);
  import ebr_pkg::*;

  localparam logic [IDXW-1:0]  DEPTH_IDX = IDXW'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] FIX_MAX   = CNT_W'(MAX_FIXED);
  localparam logic [CNT_W-1:0] ZERO_LAST = CNT_W'(MAX_ZEROS - 1);

  state_t             state;
  req_t               op;
  req_t               req;
  logic [IDXW-1:0]    fill;
  logic [IDXW-1:0]    fill_base;
  logic [IDXW-1:0]    byte_idx;
  logic [IDXW-1:0]    byte_idx_next;
  logic [2:0]         bit_idx;
  logic [7:0]         byte_reg;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   ue_val;
  logic [VALUE_W-1:0] half;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   zeros;
  logic [CNT_W-1:0]   cnt_sat;
  logic               prefix;
  logic               exh;
  logic               err;
  logic               avail;
  logic               cur_bit;
  logic               wrap;
  logic               load_acc;

  assign req       = req_t'(req_type);
  assign in_ready  = (state == ST_IDLE);
  assign load_acc  = in_valid && in_ready && (req == REQ_LOAD);
  assign fill_base = new_buffer ? '0 : fill;
  assign cnt_sat   = (bit_count > FIX_MAX) ? FIX_MAX : bit_count;

  assign avail   = (byte_idx < fill);
  assign cur_bit = avail & byte_reg[3'd7 - bit_idx];
  assign wrap    = avail && (bit_idx == 3'd7);

  always_comb begin
    byte_idx_next = byte_idx;
    if (load_acc && new_buffer) begin
      byte_idx_next = '0;
    end else if (state == ST_BITS && wrap) begin
      byte_idx_next = byte_idx + IDXW'(1);
    end
  end

  assign rd_addr = byte_idx_next[AW-1:0];
  assign wr_en   = load_acc && (fill_base < DEPTH_IDX);
  assign wr_addr = fill_base[AW-1:0];
  assign wr_data = byte_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      byte_idx <= '0;
      bit_idx  <= '0;
    end else begin
      byte_idx <= byte_idx_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (req == REQ_LOAD) begin
              if (new_buffer) begin
                bit_idx <= '0;
              end
              if (fill_base < DEPTH_IDX) begin
                fill <= fill_base + IDXW'(1);
              end else begin
                fill <= fill_base;
              end
            end else begin
              op        <= req;
              acc       <= '0;
              zeros     <= '0;
              exh       <= 1'b0;
              err       <= 1'b0;
              prefix    <= (req != REQ_FIXED);
              remaining <= cnt_sat;
              if (req == REQ_FIXED && cnt_sat == '0) begin
                state <= ST_DONE;
              end else begin
                state <= ST_FETCH;
              end
            end
          end
        end
        ST_FETCH: begin
          byte_reg <= rd_data;
          state    <= ST_BITS;
        end
        ST_BITS: begin
          if (avail) begin
            bit_idx <= bit_idx + 3'd1;
          end else begin
            exh <= 1'b1;
          end
          if (prefix) begin
            if (cur_bit) begin
              prefix    <= 1'b0;
              acc       <= ACC_W'(1);
              remaining <= zeros;
              if (zeros == '0) begin
                state <= ST_DONE;
              end else if (wrap) begin
                state <= ST_FETCH;
              end
            end else begin
              zeros <= zeros + CNT_W'(1);
              if (zeros == ZERO_LAST) begin
                err   <= 1'b1;
                state <= ST_DONE;
              end else if (wrap) begin
                state <= ST_FETCH;
              end
            end
          end else begin
            acc       <= {acc[ACC_W-2:0], cur_bit};
            remaining <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= ST_DONE;
            end else if (wrap) begin
              state <= ST_FETCH;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // se: acc = k + 1, so an even acc gives +acc/2 and an odd acc gives -(acc/2)
  assign ue_val = acc - ACC_W'(1);
  assign half   = {2'b00, acc[ACC_W-1:1]};

  always_comb begin
    res.valid      = (state == ST_DONE);
    res.exhausted  = exh;
    res.code_error = err;
    if (err) begin
      res.value = '0;
    end else begin
      unique case (op)
        REQ_UE:  res.value = {1'b0, ue_val};
        REQ_SE:  res.value = acc[0] ? (~half + VALUE_W'(1)) : half;
        default: res.value = {1'b0, acc};
      endcase
    end
  end

  a_idx_within_fill: assert property (@(posedge clk) disable iff (rst)
    byte_idx <= fill) else $error("read position beyond fill");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_IDX) else $error("fill count beyond buffer");

  a_no_advance_when_dry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BITS && !avail) |=> ($stable(byte_idx) && $stable(bit_idx)))
    else $error("position moved past end of data");

  a_err_only_eg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && err) |-> (op != REQ_FIXED && zeros == CNT_W'(MAX_ZEROS)))
    else $error("code error on fixed read or short prefix");

endmodule

// ----- src/exp_golomb_bit_reader.sv -----
// ----------------------------------------------------------------------------
// exp_golomb_bit_reader
// Byte-buffered bitstream reader with fixed, ue and se Exp-Golomb reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_t*. s_tuser carries the request kind and the
//   new-buffer flag; s_tdata carries the byte to load and the fixed width.
//   A load gives no output item; loads can follow every cycle while no
//   read is in progress. A read gives exactly one output item on m_t*:
//   value in m_tdata, exhausted and code_error in m_tuser.
//   After acceptance a read fetches its first byte from the buffer and
//   then examines bit positions, including those past the end of data. The
//   sequencer takes one bit per cycle between fetches; each new byte that
//   is needed while bits are still to be taken costs another buffer fetch.
//   A zero-width fixed read skips the buffer and goes straight to its
//   result. The next item is taken in the cycle after the result enters
//   the output register.
//   Reset clears the fill count and the read position; the buffer contents
//   are left as they are and only written bytes are ever read.
//   The output register lets the next item be taken while a result waits;
//   a further read finishing while m_tready stays low holds until it drains.
// ----------------------------------------------------------------------------
module exp_golomb_bit_reader #(
  parameter int BUFFER_BYTES = ebr_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ebr_pkg::S_TDATA_W-1:0] s_tdata,  // byte_value[7:0], bit_count[13:8], zeros
  input  logic [ebr_pkg::S_TUSER_W-1:0] s_tuser,  // req_type[1:0], new_buffer[2]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ebr_pkg::M_TDATA_W-1:0] m_tdata,  // value[32:0], zeros
  output logic [ebr_pkg::M_TUSER_W-1:0] m_tuser   // exhausted[0], code_error[1]
);
  import ebr_pkg::*;

  localparam int AW   = $clog2(BUFFER_BYTES);
  localparam int IDXW = $clog2(BUFFER_BYTES + 1);

  res_t               res;
  logic               out_free;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [AW-1:0]      rd_addr;
  logic [7:0]         rd_data;
  logic [VALUE_W-1:0] value;
  logic               exhausted;
  logic               code_error;

  assign out_free = !m_tvalid || m_tready;

  ebr_store #(
    .DEPTH (BUFFER_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ebr_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .AW           (AW),
    .IDXW         (IDXW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser[1:0]),
    .byte_value (s_tdata[7:0]),
    .new_buffer (s_tuser[2]),
    .bit_count  (s_tdata[13:8]),
    .out_free   (out_free),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      value      <= res.value;
      exhausted  <= res.exhausted;
      code_error <= res.code_error;
    end
  end

  assign m_tdata = {(M_TDATA_W - VALUE_W)'(0), value};
  assign m_tuser = {code_error, exhausted};

endmodule
